FILE: sv/periodic_stream_scheduler_macros.svh
// assertion macros for the periodic stream scheduler
`ifndef PERIODIC_STREAM_SCHEDULER_MACROS_SVH
`define PERIODIC_STREAM_SCHEDULER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PSS_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("pss assertion failed");

// next-cycle implication, disabled while in reset
`define PSS_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("pss assertion failed");

`endif

FILE: sv/pss_pkg.sv
// types and constants shared by the periodic stream scheduler
package pss_pkg;

    localparam int MAX_STREAMS = 16;
    localparam int IDX_W       = $clog2(MAX_STREAMS);
    localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_START = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_STOP  = CFG_IDX_W'(3);

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [63:0] TIME_NONE = '1;

    typedef struct packed {
        logic             mode;
        logic [IDX_W-1:0] stream_sel;
        logic [63:0]      stream_interval;
        logic             stream_reliable;
        logic             stream_broadcast;
        logic [63:0]      now_ns;
    } t_cmd;

    typedef struct packed {
        logic             granted;
        logic [63:0]      slot_time;
        logic [63:0]      slot_sequence;
        logic [IDX_W-1:0] slot_stream;
        logic             flag_reliable;
        logic             flag_broadcast;
        logic             flag_measure;
        logic [63:0]      earliest_due;
        logic             config_error;
    } t_res;

    // one stream table row
    typedef struct packed {
        logic [63:0] interval;
        logic [63:0] sequence_no;
        logic [63:0] due;
        logic        broadcast;
        logic        reliable;
    } t_entry;

    typedef enum logic [0:0] {
        ALU_LT  = 1'b0,
        ALU_ADD = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [63:0] value;
        logic        flag;
    } t_alu_rsp;

endpackage

FILE: sv/periodic_stream_scheduler.sv
// periodic stream scheduler top level: stream table, sequencer and result register
//
//  channel   signals                               transfer when
//  command   i_start, o_busy, i_cmd                i_start && !o_busy
//  result    o_res_valid, o_res                    o_res_valid (one cycle strobe)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_*     i_cfg_valid && o_cfg_ready
//
// n = min(stream_count, 16). A scan of the stream table makes one read of the
// table memory and one compare in the shared unit per stream. A load scans once
// before the strobe; a request without grant scans and then checks the due time.
// A request with grant takes two scans, five shared-unit steps and the write back.
// Reset is synchronous and active low; the table itself is not cleared.
// The result strobe cannot be stalled; config is always ready.
`include "periodic_stream_scheduler_macros.svh"

module periodic_stream_scheduler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  pss_pkg::t_cmd                       i_cmd,
    output logic                                o_res_valid,
    output pss_pkg::t_res                       o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [63:0]                         i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_ADD    = 8'b0000_1000,
        S_INC    = 8'b0001_0000,
        S_MSTART = 8'b0010_0000,
        S_MSTOP  = 8'b0100_0000,
        S_WRITE  = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic [pss_pkg::CNT_W-1:0] r_count;
    logic [63:0]               r_start_time;
    logic [63:0]               r_mstart;
    logic [63:0]               r_mstop;

    pss_pkg::t_entry r_mem [pss_pkg::MAX_STREAMS];
    pss_pkg::t_entry r_rd;

    logic [pss_pkg::IDX_W-1:0] rd_addr;
    logic                      mem_we;
    logic [pss_pkg::IDX_W-1:0] mem_wa;
    pss_pkg::t_entry           mem_wd;

    logic [pss_pkg::CNT_W-1:0] r_iss;
    logic                      r_pend;
    logic [pss_pkg::IDX_W-1:0] r_cmp_idx;
    logic [63:0]               r_best;
    logic [pss_pkg::IDX_W-1:0] r_best_idx;
    logic                      r_found;
    logic                      r_post;
    logic [63:0]               r_now;
    logic [63:0]               r_new_due;
    logic [63:0]               r_new_seq;
    logic                      r_meas_lo;

    logic          r_res_valid;
    pss_pkg::t_res r_res;

    pss_pkg::t_alu_req alu_req;
    pss_pkg::t_alu_rsp alu_rsp;

    logic [pss_pkg::CNT_W-1:0] n_act;
    logic                      accept;
    logic                      load_err;
    logic                      scan_issue;
    logic                      scan_done;
    logic                      grant;
    logic                      res_fire;
    pss_pkg::t_res             start_res;

    // oversized count acts as the table depth
    assign n_act = (r_count > pss_pkg::CNT_W'(pss_pkg::MAX_STREAMS))
                 ? pss_pkg::CNT_W'(pss_pkg::MAX_STREAMS) : r_count;

    assign accept   = i_start && !o_busy;
    assign load_err = (i_cmd.stream_interval == 64'd0)
                   || ({1'b0, i_cmd.stream_sel} >= n_act);

    assign scan_issue = r_iss < n_act;
    assign scan_done  = !scan_issue && !r_pend;
    assign grant      = r_found && !alu_rsp.flag;

    // result strobe after the final scan, or straight from the due check
    assign res_fire = ((r_state == S_SCAN) && scan_done && r_post)
                   || ((r_state == S_CHECK) && !grant);

    always_comb begin
        start_res              = '0;
        start_res.config_error = (i_cmd.mode == pss_pkg::MODE_LOAD) && load_err;
    end

    pss_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    always_comb begin
        alu_req    = '0;
        alu_req.op = pss_pkg::ALU_LT;
        unique case (r_state)
            S_SCAN: begin
                alu_req.a = r_rd.due;
                alu_req.b = r_best;
            end
            S_CHECK: begin
                alu_req.a = r_now;
                alu_req.b = r_best;
            end
            S_ADD: begin
                alu_req.op = pss_pkg::ALU_ADD;
                alu_req.a  = r_rd.due;
                alu_req.b  = r_rd.interval;
            end
            S_INC: begin
                alu_req.op = pss_pkg::ALU_ADD;
                alu_req.a  = r_rd.sequence_no;
                alu_req.b  = 64'd1;
            end
            S_MSTART: begin
                alu_req.a = r_best;
                alu_req.b = r_mstart;
            end
            S_MSTOP: begin
                alu_req.a = r_best;
                alu_req.b = r_mstop;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    // table write port: a load at its transfer, or the grant write back
    always_comb begin
        rd_addr = (r_state == S_SCAN) ? r_iss[pss_pkg::IDX_W-1:0] : r_best_idx;
        mem_we  = 1'b0;
        mem_wa  = r_best_idx;
        mem_wd  = r_rd;
        if (r_state == S_WRITE) begin
            mem_we             = 1'b1;
            mem_wd.due         = r_new_due;
            mem_wd.sequence_no = r_new_seq;
        end else if (accept && i_cmd.mode == pss_pkg::MODE_LOAD && !load_err) begin
            mem_we           = 1'b1;
            mem_wa           = i_cmd.stream_sel;
            mem_wd.interval  = i_cmd.stream_interval;
            mem_wd.sequence_no = 64'd1;
            mem_wd.due       = r_start_time;
            mem_wd.broadcast = i_cmd.stream_broadcast;
            mem_wd.reliable  = i_cmd.stream_reliable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_start_time <= '0;
            r_mstart     <= '0;
            r_mstop      <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pss_pkg::CFG_STREAM_COUNT:  r_count      <= i_cfg_data[pss_pkg::CNT_W-1:0];
                pss_pkg::CFG_START_TIME:    r_start_time <= i_cfg_data;
                pss_pkg::CFG_MEASURE_START: r_mstart     <= i_cfg_data;
                pss_pkg::CFG_MEASURE_STOP:  r_mstop      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_iss       <= '0;
            r_post      <= 1'b0;
        end else begin
            r_res_valid <= res_fire;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res   <= start_res;
                        r_post  <= (i_cmd.mode == pss_pkg::MODE_LOAD);
                        r_now   <= i_cmd.now_ns;
                        r_iss   <= '0;
                        r_pend  <= 1'b0;
                        r_best  <= pss_pkg::TIME_NONE;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_cmp_idx <= r_iss[pss_pkg::IDX_W-1:0];
                        r_iss     <= r_iss + 1'b1;
                    end
                    // strict compare keeps the lowest index on ties
                    if (r_pend && alu_rsp.flag) begin
                        r_best     <= r_rd.due;
                        r_best_idx <= r_cmp_idx;
                        r_found    <= 1'b1;
                    end
                    if (scan_done) begin
                        if (r_post) begin
                            r_res.earliest_due <= r_best;
                            r_state            <= S_IDLE;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    if (grant) begin
                        r_res.granted     <= 1'b1;
                        r_res.slot_time   <= r_best;
                        r_res.slot_stream <= r_best_idx;
                        r_state           <= S_ADD;
                    end else begin
                        r_res.earliest_due <= r_best;
                        r_state            <= S_IDLE;
                    end
                end
                S_ADD: begin
                    r_new_due            <= alu_rsp.value;
                    r_res.slot_sequence  <= r_rd.sequence_no;
                    r_res.flag_reliable  <= r_rd.reliable;
                    r_res.flag_broadcast <= r_rd.broadcast;
                    r_state              <= S_INC;
                end
                S_INC: begin
                    r_new_seq <= alu_rsp.value;
                    r_state   <= S_MSTART;
                end
                S_MSTART: begin
                    r_meas_lo <= !alu_rsp.flag;
                    r_state   <= S_MSTOP;
                end
                S_MSTOP: begin
                    r_res.flag_measure <= r_meas_lo && alu_rsp.flag;
                    r_state            <= S_WRITE;
                end
                S_WRITE: begin
                    // rescan for the earliest due time after the update
                    r_post  <= 1'b1;
                    r_iss   <= '0;
                    r_pend  <= 1'b0;
                    r_best  <= pss_pkg::TIME_NONE;
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

    `PSS_ASSERT_NXT(a_busy_after_start, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `PSS_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_res_valid, !o_res_valid)
    `PSS_ASSERT_IMP(a_grant_no_error, i_clk, i_rst_n, o_res_valid && o_res.granted, !o_res.config_error)
    `PSS_ASSERT_IMP(a_no_grant_zero, i_clk, i_rst_n, o_res_valid && !o_res.granted,
        o_res.slot_time == 64'd0 && o_res.slot_sequence == 64'd0 && !o_res.flag_measure)

endmodule

FILE: sv/pss_alu.sv
// shared 64-bit compare and saturating add unit
module pss_alu (
    input  pss_pkg::t_alu_req i_req,
    output pss_pkg::t_alu_rsp o_rsp
);

    logic [64:0] sum;

    assign sum = {1'b0, i_req.a} + {1'b0, i_req.b};

    always_comb begin
        o_rsp = '0;
        unique case (i_req.op)
            pss_pkg::ALU_LT: begin
                o_rsp.flag = i_req.a < i_req.b;
            end
            pss_pkg::ALU_ADD: begin
                // saturate on carry out
                o_rsp.value = sum[64] ? pss_pkg::TIME_NONE : sum[63:0];
                o_rsp.flag  = sum[64];
            end
            default: begin
                o_rsp = '0;
            end
        endcase
    end

endmodule

FILE: sim/periodic_stream_scheduler_checker.sv
// slot predictor and result scoreboard for the periodic stream scheduler
module periodic_stream_scheduler_checker
    import pss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_cmd                 i_cmd,
    input  logic                 i_res_valid,
    input  t_res                 i_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [4:0]  stream_count;
    logic [63:0] start_time;
    logic [63:0] window_open;
    logic [63:0] window_close;
    logic [63:0] period_tbl [MAX_STREAMS];
    logic [1:0]  attr_tbl   [MAX_STREAMS];
    logic [63:0] due_tbl    [MAX_STREAMS];
    logic [63:0] seq_tbl    [MAX_STREAMS];
    t_res        slot_q [$];
    int          mismatches;

    function automatic int active_streams();
        return (stream_count > MAX_STREAMS) ? MAX_STREAMS : int'(stream_count);
    endfunction

    // lowest index wins ties, an all ones due time is never picked
    function automatic int earliest_stream(output logic [63:0] due);
        int pick;
        pick = -1;
        due  = TIME_NONE;
        for (int i = 0; i < active_streams(); i++) begin
            if (due_tbl[i] < due) begin
                due  = due_tbl[i];
                pick = i;
            end
        end
        return pick;
    endfunction

    function automatic t_res schedule_step(input t_cmd c);
        t_res        r;
        logic [63:0] due;
        logic [64:0] sum;
        int          pick;
        r = '0;
        if (c.mode == MODE_LOAD) begin
            if (c.stream_interval == 64'd0 || int'(c.stream_sel) >= active_streams()) begin
                r.config_error = 1'b1;
            end else begin
                period_tbl[c.stream_sel] = c.stream_interval;
                attr_tbl[c.stream_sel]   = {c.stream_broadcast, c.stream_reliable};
                due_tbl[c.stream_sel]    = start_time;
                seq_tbl[c.stream_sel]    = 64'd1;
            end
        end else begin
            pick = earliest_stream(due);
            if (pick >= 0 && due <= c.now_ns) begin
                r.granted        = 1'b1;
                r.slot_time      = due;
                r.slot_sequence  = seq_tbl[pick];
                r.slot_stream    = IDX_W'(pick);
                r.flag_reliable  = attr_tbl[pick][0];
                r.flag_broadcast = attr_tbl[pick][1];
                r.flag_measure   = (due >= window_open) && (due < window_close);
                // due time and sequence both stick at all ones
                sum = {1'b0, due} + {1'b0, period_tbl[pick]};
                due_tbl[pick] = sum[64] ? TIME_NONE : sum[63:0];
                if (seq_tbl[pick] != '1) begin
                    seq_tbl[pick] = seq_tbl[pick] + 64'd1;
                end
            end
        end
        pick = earliest_stream(due);
        r.earliest_due = due;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t checker: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_slot(input t_res want, input t_res got);
        check_field("granted", 64'(want.granted), 64'(got.granted));
        check_field("slot_time", want.slot_time, got.slot_time);
        check_field("slot_sequence", want.slot_sequence, got.slot_sequence);
        check_field("slot_stream", 64'(want.slot_stream), 64'(got.slot_stream));
        check_field("flag_reliable", 64'(want.flag_reliable), 64'(got.flag_reliable));
        check_field("flag_broadcast", 64'(want.flag_broadcast), 64'(got.flag_broadcast));
        check_field("flag_measure", 64'(want.flag_measure), 64'(got.flag_measure));
        check_field("earliest_due", want.earliest_due, got.earliest_due);
        check_field("config_error", 64'(want.config_error), 64'(got.config_error));
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_res want;
        if (!i_rst_n) begin
            stream_count = '0;
            start_time   = '0;
            window_open  = '0;
            window_close = '0;
            for (int i = 0; i < MAX_STREAMS; i++) begin
                period_tbl[i] = '0;
                attr_tbl[i]   = '0;
                due_tbl[i]    = '0;
                seq_tbl[i]    = '0;
            end
            slot_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STREAM_COUNT:  stream_count = i_cfg_data[4:0];
                    CFG_START_TIME:    start_time   = i_cfg_data;
                    CFG_MEASURE_START: window_open  = i_cfg_data;
                    CFG_MEASURE_STOP:  window_close = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                slot_q.push_back(schedule_step(i_cmd));
            end
            if (i_res_valid) begin
                if (slot_q.size() == 0) begin
                    $display("%0t checker: expected no result, got %h", $time, i_res);
                    mismatches++;
                end else begin
                    want = slot_q.pop_front();
                    compare_slot(want, i_res);
                end
            end
        end
        o_pending    <= slot_q.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: sim/periodic_stream_scheduler_tb.sv
// testbench top for the periodic stream scheduler: stimulus, watchdog and verdict
module periodic_stream_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pss_pkg::*;

    localparam int ITEM_TARGET    = 850;
    localparam int GAP_MAX        = 11;
    localparam int WATCHDOG_LIMIT = 2000;
    // a granted request scans the table twice
    localparam int SETTLE_CYCLES  = 2 * MAX_STREAMS + 16;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_start     = 1'b0;
    logic                   o_busy;
    t_cmd                   i_cmd       = '0;
    logic                   o_res_valid;
    t_res                   o_res;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [63:0]            i_cfg_data  = '0;
    int                     fail_count;
    int                     pending;

    int                     active_n      = 0;
    logic [MAX_STREAMS-1:0] loaded        = '0;
    logic [63:0]            last_due      = TIME_NONE;
    logic [63:0]            cur_start     = '0;
    bit                     steady        = 1'b0;
    int                     cmd_count     = 0;
    int                     request_count = 0;
    int                     grant_count   = 0;
    int                     reject_count  = 0;
    int                     write_count   = 0;
    int                     phase_count   = 0;
    int                     quiet         = 0;

    always #2 i_clk = ~i_clk;

    periodic_stream_scheduler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    periodic_stream_scheduler_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // last reported earliest due time steers the request times
    always @(posedge i_clk) begin
        if (o_res_valid) begin
            last_due <= o_res.earliest_due;
            if (o_res.granted) grant_count <= grant_count + 1;
            if (o_res.config_error) reject_count <= reject_count + 1;
        end
        if (!i_rst_n || (i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, quiet);
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_interval();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return 64'd0;
        if (r < 55) return 64'($urandom_range(1, 64));
        if (r < 75) return 64'($urandom_range(1, 1 << 20));
        if (r < 88) return rand64();
        if (r < 95) return TIME_NONE - 64'($urandom_range(0, 3));
        return 64'h8000_0000_0000_0000;
    endfunction

    function automatic logic [63:0] pick_now();
        int unsigned r;
        logic [63:0] t;
        r = $urandom_range(0, 99);
        if (r < 10 || last_due == TIME_NONE) return rand64();
        if (r < 18) return TIME_NONE;
        if (r < 33) return (last_due > 64'd64) ? last_due - 64'($urandom_range(1, 64)) : 64'd0;
        t = last_due + 64'($urandom_range(0, 400));
        return (t < last_due) ? TIME_NONE : t;
    endfunction

    function automatic logic [CFG_IDX_W-1:0] spare_index();
        // indexes above the last register are ignored by the block
        return CFG_IDX_W'($urandom_range(int'(CFG_MEASURE_STOP) + 1, (1 << CFG_IDX_W) - 1));
    endfunction

    function automatic t_cmd load_cmd(input logic [IDX_W-1:0] sel, input logic [63:0] period,
                                      input logic must, input logic bcast);
        t_cmd c;
        c.mode             = MODE_LOAD;
        c.stream_sel       = sel;
        c.stream_interval  = period;
        c.stream_reliable  = must;
        c.stream_broadcast = bcast;
        c.now_ns           = rand64();
        return c;
    endfunction

    function automatic t_cmd request_cmd(input logic [63:0] now);
        t_cmd c;
        c.mode             = MODE_REQUEST;
        c.stream_sel       = IDX_W'($urandom);
        c.stream_interval  = rand64();
        c.stream_reliable  = 1'($urandom);
        c.stream_broadcast = 1'($urandom);
        c.now_ns           = now;
        return c;
    endfunction

    // start stays high when the next command follows with no gap
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        do @(posedge i_clk); while (o_busy);
        cmd_count++;
        if (c.mode == MODE_REQUEST) request_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] data);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_STREAM_COUNT) begin
            active_n = (data[4:0] > MAX_STREAMS) ? MAX_STREAMS : int'(data[4:0]);
        end
        write_count++;
    endtask

    task automatic wait_drained();
        i_start     <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || o_busy);
        repeat (2) @(posedge i_clk);
    endtask

    // every active entry must hold a stream before any request
    task automatic load_missing();
        logic [63:0] period;
        for (int i = 0; i < active_n; i++) begin
            if (!loaded[i]) begin
                do period = pick_interval(); while (period == 64'd0);
                send_cmd(load_cmd(IDX_W'(i), period, 1'($urandom), 1'($urandom)));
                loaded[i] = 1'b1;
            end
        end
    endtask

    task automatic random_phase();
        logic [63:0] data;
        logic [63:0] lo;
        logic [63:0] period;
        int unsigned r;
        int          sel;
        wait_drained();
        phase_count++;
        steady = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 6) data = 64'd0;
        else if (r < 16) data = 64'd1;
        else if (r < 36) data = 64'd16;
        else if (r < 46) data = 64'($urandom_range(17, 31));
        else data = 64'($urandom_range(2, 15));
        // junk above the five count bits now and then
        if ($urandom_range(0, 3) == 0) data = (rand64() & ~64'h1f) | data;
        write_reg(CFG_STREAM_COUNT, data);
        if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 15) cur_start = 64'd0;
            else if (r < 50) cur_start = 64'($urandom);
            else if (r < 75) cur_start = rand64();
            else if (r < 90) cur_start = TIME_NONE - 64'($urandom_range(0, 1000));
            else cur_start = TIME_NONE;
            write_reg(CFG_START_TIME, cur_start);
        end
        if ($urandom_range(0, 1) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                lo   = cur_start + 64'($urandom_range(0, 200));
                data = lo + 64'($urandom_range(0, 300));
            end else if (r < 60) begin
                lo   = rand64();
                data = rand64();
            end else if (r < 75) begin
                lo   = 64'd0;
                data = TIME_NONE;
            end else if (r < 88) begin
                // start above stop: empty window
                data = cur_start;
                lo   = cur_start + 64'($urandom_range(1, 100));
            end else begin
                lo   = cur_start;
                data = cur_start;
            end
            write_reg(CFG_MEASURE_START, lo);
            write_reg(CFG_MEASURE_STOP, data);
        end
        if ($urandom_range(0, 7) == 0) write_reg(spare_index(), rand64());
        i_cfg_valid <= 1'b0;
        load_missing();
        repeat ($urandom_range(15, 50)) begin
            if (cmd_count < ITEM_TARGET) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    if (active_n > 0 && $urandom_range(0, 3) != 0) begin
                        sel = $urandom_range(0, active_n - 1);
                    end else begin
                        sel = $urandom_range(0, MAX_STREAMS - 1);
                    end
                    period = pick_interval();
                    send_cmd(load_cmd(IDX_W'(sel), period, 1'($urandom), 1'($urandom)));
                    if (sel < active_n && period != 64'd0) loaded[sel] = 1'b1;
                end else begin
                    send_cmd(request_cmd(pick_now()));
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // no active streams: nothing to grant, every load rejected
        send_cmd(request_cmd(64'd0));
        send_cmd(load_cmd(IDX_W'(0), 64'd7, 1'b1, 1'b1));
        wait_drained();
        write_reg(CFG_STREAM_COUNT, 64'd2);
        write_reg(CFG_START_TIME, 64'd100);
        write_reg(CFG_MEASURE_START, 64'd100);
        write_reg(CFG_MEASURE_STOP, 64'd101);
        i_cfg_valid <= 1'b0;
        cur_start = 64'd100;
        send_cmd(load_cmd(IDX_W'(0), 64'd0, 1'b1, 1'b0));
        send_cmd(load_cmd(IDX_W'(2), 64'd5, 1'b0, 1'b1));
        send_cmd(load_cmd(IDX_W'(0), 64'd10, 1'b1, 1'b0));
        send_cmd(load_cmd(IDX_W'(1), TIME_NONE, 1'b0, 1'b1));
        loaded[1:0] = 2'b11;
        send_cmd(request_cmd(64'd99));
        // both due at 100: the tie goes to stream 0
        send_cmd(request_cmd(64'd100));
        // stream 1 then sticks at all ones
        send_cmd(request_cmd(TIME_NONE));
        send_cmd(request_cmd(TIME_NONE));
        wait_drained();
        write_reg(CFG_START_TIME, TIME_NONE);
        i_cfg_valid <= 1'b0;
        cur_start = TIME_NONE;
        send_cmd(load_cmd(IDX_W'(0), 64'd3, 1'b1, 1'b1));
        send_cmd(request_cmd(TIME_NONE));
        wait_drained();
        // a count above the table size acts as the full table
        write_reg(CFG_STREAM_COUNT, 64'd17);
        write_reg(spare_index(), rand64());
        i_cfg_valid <= 1'b0;
        send_cmd(load_cmd(IDX_W'(15), 64'd1, 1'b0, 1'b0));
        loaded[15] = 1'b1;
        while (cmd_count < ITEM_TARGET) random_phase();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d commands: %0d slot requests, %0d grants, %0d rejected loads",
                 cmd_count, request_count, grant_count, reject_count);
        $display("stream table reconfigured %0d times through %0d register writes",
                 phase_count, write_count);
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/pss_pkg.sv
sv/pss_alu.sv
sv/periodic_stream_scheduler.sv
sim/periodic_stream_scheduler_checker.sv
sim/periodic_stream_scheduler_tb.sv
